>>> design/bsfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfd_pkg
// shared codes, marker bytes and the result type of the frame decoder
// ----------------------------------------------------------------------------
package bsfd_pkg;

  // marker bytes of the stuffed stream
  localparam logic [7:0] BYTE_SOF     = 8'hFE;
  localparam logic [7:0] BYTE_EOF     = 8'hFF;
  localparam logic [7:0] BYTE_ESC     = 8'hFD;
  localparam logic [7:0] ESC_XOR_MASK = 8'h20;

  // crc-16/x.25, reflected
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h8408;
  localparam logic [15:0] CRC_RESIDUE = 16'hF0B8;

  // header field values
  localparam logic [7:0] HDR_SLOT     = 8'h00;
  localparam logic [7:0] HDR_MSG_TYPE = 8'h0E;
  localparam logic [7:0] HDR_CMD_MAX  = 8'h02;
  localparam logic [7:0] HDR_VERSION  = 8'h01;
  localparam logic [7:0] HDR_DTD      = 8'h01;
  localparam logic [7:0] HDR_APP_LEN  = 8'h02;
  localparam logic [3:0] FLAGS_LOW_MASK = 4'hF;

  // result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  // command codes
  localparam logic [1:0] CMD_DATA = 2'd0;

  // end status codes
  localparam logic [1:0] STAT_GOOD      = 2'd0;
  localparam logic [1:0] STAT_CRC_BAD   = 2'd1;
  localparam logic [1:0] STAT_HDR_BAD   = 2'd2;
  localparam logic [1:0] STAT_TOO_SHORT = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] command;
    logic [7:0] flags;
    logic [7:0] minor;
    logic [7:0] major;
    logic [1:0] status;
  } result_t;

endpackage

>>> design/byte_stuffed_frame_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stuffed_frame_decoder
// byte-unstuffing deframer with header check and crc-16/x.25 frame check
// ----------------------------------------------------------------------------
// usage
//   rx channel (rx_valid_i / rx_ready_o / rx_byte_i) takes one raw byte of
//   the stuffed stream per item; 0xfe opens or restarts a frame, 0xfd
//   escapes the next byte, 0xff closes the frame
//   res channel (res_valid_o / res_ready_i) gives at most one result item
//   per byte: header accepted, payload byte, or end of frame with status
//   results: a byte is decoded straight out of the input register; the
//   result it gives, if any, is written into the result buffer, which
//   drives res_valid_o
//   throughput: one byte per cycle while the result buffer has space,
//   with the crc step and header check combinational in between
//   stall: a two-entry result buffer lets input keep flowing while a
//   result waits; when it is full the decode stage holds and rx_ready_o
//   drops once the input register is occupied
//   reset: the decoder returns to idle outside any frame, the crc to
//   0xffff, and both the input register and the result buffer empty
// ----------------------------------------------------------------------------
module byte_stuffed_frame_decoder
  import bsfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // raw byte channel
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  // result channel
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic [1:0] result_kind_o,
  output logic [7:0] data_byte_o,
  output logic [1:0] command_code_o,
  output logic [7:0] flags_byte_o,
  output logic [7:0] app_minor_version_o,
  output logic [7:0] app_major_version_o,
  output logic [1:0] frame_status_o
);

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;

  // decode stage control
  logic       buf_space;
  logic       advance;
  logic       dec_valid;
  result_t    dec_res;
  result_t    out_res;

  // the decode stage moves only when the buffer can take a result
  assign advance    = in_valid_q && buf_space;
  assign rx_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    priority if (rx_valid_i && rx_ready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // byte register carries data only and has no reset
  always_ff @(posedge clk_i) begin
    if (rx_valid_i && rx_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // unescape, crc, header check and payload hold
  bsfd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (advance),
    .byte_i       (in_byte_q),
    .res_valid_o  (dec_valid),
    .res_o        (dec_res)
  );

  // result buffer decouples the receiver from the decode stage
  bsfd_out_fifo u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (dec_valid),
    .wr_data_i  (dec_res),
    .space_o    (buf_space),
    .rd_valid_o (res_valid_o),
    .rd_ready_i (res_ready_i),
    .rd_data_o  (out_res)
  );

  assign result_kind_o       = out_res.kind;
  assign data_byte_o         = out_res.data;
  assign command_code_o      = out_res.command;
  assign flags_byte_o        = out_res.flags;
  assign app_minor_version_o = out_res.minor;
  assign app_major_version_o = out_res.major;
  assign frame_status_o      = out_res.status;

endmodule

>>> design/bsfd_crc16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfd_crc16
// one byte step of the reflected crc-16/x.25
// ----------------------------------------------------------------------------
module bsfd_crc16
  import bsfd_pkg::*;
(
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  logic [15:0] work;

  always_comb begin
    work = crc_i ^ {8'h00, byte_i};
    for (int i = 0; i < 8; i++) begin
      if (work[0]) begin
        work = (work >> 1) ^ CRC_POLY;
      end else begin
        work = work >> 1;
      end
    end
    crc_o = work;
  end

endmodule

>>> design/bsfd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfd_core
// frame state, unescaping, header check and payload hold, one byte a cycle
// ----------------------------------------------------------------------------
module bsfd_core
  import bsfd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    byte_valid_i,
  input  logic [7:0] byte_i,
  output logic    res_valid_o,
  output result_t res_o
);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_REJECT  = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [3:0]  pos_q, pos_d;
  logic        esc_q, esc_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  hold0_q, hold0_d, hold1_q, hold1_d;
  logic [1:0]  hold_cnt_q, hold_cnt_d;
  logic [1:0]  cmd_q, cmd_d;
  logic [7:0]  flags_q, flags_d;
  logic [7:0]  minor_q, minor_d;

  logic [7:0]  data_b;
  logic [15:0] crc_next;
  logic        take_data;
  logic        hdr_ok;
  logic        hdr_done;

  assign data_b = esc_q ? (byte_i ^ ESC_XOR_MASK) : byte_i;

  bsfd_crc16 u_crc (
    .crc_i  (crc_q),
    .byte_i (data_b),
    .crc_o  (crc_next)
  );

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    esc_d      = esc_q;
    crc_d      = crc_q;
    hold0_d    = hold0_q;
    hold1_d    = hold1_q;
    hold_cnt_d = hold_cnt_q;
    cmd_d      = cmd_q;
    flags_d    = flags_q;
    minor_d    = minor_q;
    take_data  = 1'b0;
    hdr_ok     = 1'b1;
    hdr_done   = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (byte_valid_i) begin
      if (byte_i == BYTE_SOF) begin
        phase_d    = PH_HEADER;
        pos_d      = '0;
        esc_d      = 1'b0;
        crc_d      = CRC_INIT;
        hold_cnt_d = '0;
        cmd_d      = '0;
        flags_d    = '0;
        minor_d    = '0;
      end else if (phase_q != PH_IDLE) begin
        if (esc_q) begin
          esc_d     = 1'b0;
          take_data = 1'b1;
        end else if (byte_i == BYTE_ESC) begin
          esc_d = 1'b1;
        end else if (byte_i == BYTE_EOF) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_END;
          priority if (phase_q == PH_HEADER) begin
            res_o.status = STAT_TOO_SHORT;
          end else if (phase_q == PH_REJECT) begin
            res_o.status = STAT_HDR_BAD;
          end else if (hold_cnt_q != 2'd2) begin
            res_o.status = STAT_TOO_SHORT;
          end else if (crc_q == CRC_RESIDUE) begin
            res_o.status = STAT_GOOD;
          end else begin
            res_o.status = STAT_CRC_BAD;
          end
          phase_d    = PH_IDLE;
          pos_d      = '0;
          hold_cnt_d = '0;
        end else begin
          take_data = 1'b1;
        end
      end
    end

    if (take_data) begin
      crc_d = crc_next;
      unique case (phase_q)
        PH_HEADER: begin
          unique case (pos_q)
            4'd0: hdr_ok = (data_b == HDR_SLOT);
            4'd1: hdr_ok = (data_b == HDR_MSG_TYPE);
            4'd2: begin
              hdr_ok = (data_b <= HDR_CMD_MAX);
              cmd_d  = data_b[1:0];
            end
            4'd3: begin
              hdr_ok   = (data_b == HDR_VERSION);
              hdr_done = (cmd_q != CMD_DATA);
            end
            4'd4: begin
              hdr_ok  = (data_b[3:0] & FLAGS_LOW_MASK) == 4'h0;
              flags_d = data_b;
            end
            4'd5: hdr_ok = (data_b == HDR_DTD);
            4'd6: hdr_ok = (data_b == HDR_APP_LEN);
            4'd7: minor_d = data_b;
            4'd8: hdr_done = 1'b1;
            default: hdr_ok = 1'b0;
          endcase
          if (!hdr_ok) begin
            phase_d = PH_REJECT;
          end else if (!hdr_done) begin
            pos_d = pos_q + 4'd1;
          end else begin
            phase_d       = PH_PAYLOAD;
            hold_cnt_d    = '0;
            res_valid_o   = 1'b1;
            res_o.kind    = KIND_HEADER;
            res_o.command = cmd_d;
            if (cmd_d == CMD_DATA) begin
              res_o.flags = flags_q;
              res_o.minor = minor_q;
              res_o.major = data_b;
            end
          end
        end
        PH_PAYLOAD: begin
          if (hold_cnt_q != 2'd2) begin
            if (hold_cnt_q[0]) begin
              hold1_d = data_b;
            end else begin
              hold0_d = data_b;
            end
            hold_cnt_d = hold_cnt_q + 2'd1;
          end else begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_PAYLOAD;
            res_o.data  = hold0_q;
            hold0_d     = hold1_q;
            hold1_d     = data_b;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      pos_q      <= '0;
      esc_q      <= 1'b0;
      crc_q      <= CRC_INIT;
      hold_cnt_q <= '0;
      cmd_q      <= '0;
      flags_q    <= '0;
      minor_q    <= '0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      esc_q      <= esc_d;
      crc_q      <= crc_d;
      hold_cnt_q <= hold_cnt_d;
      cmd_q      <= cmd_d;
      flags_q    <= flags_d;
      minor_q    <= minor_d;
    end
  end

  // payload hold needs no reset, only counted entries are read
  always_ff @(posedge clk_i) begin
    hold0_q <= hold0_d;
    hold1_q <= hold1_d;
  end

`ifndef ASSERT_OFF
  a_hold_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_cnt_q != 2'd3)
    else $error("hold count out of range");

  a_sof_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_valid_i && (byte_i == BYTE_SOF)
    |=> (phase_q == PH_HEADER) && (crc_q == CRC_INIT) && !esc_q && (hold_cnt_q == 2'd0))
    else $error("start byte did not restart the frame");

  a_header_from_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.kind == KIND_HEADER) |-> (phase_q == PH_HEADER))
    else $error("header result outside header phase");

  a_payload_needs_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.kind == KIND_PAYLOAD)
    |-> (phase_q == PH_PAYLOAD) && (hold_cnt_q == 2'd2))
    else $error("payload result without a full hold");
`endif

endmodule

>>> design/bsfd_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfd_out_fifo
// two-entry result buffer between the decoder and the result channel
// ----------------------------------------------------------------------------
module bsfd_out_fifo
  import bsfd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_valid_i,
  input  result_t wr_data_i,
  output logic    space_o,
  output logic    rd_valid_o,
  input  logic    rd_ready_i,
  output result_t rd_data_o
);

  result_t    mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       do_rd;

  assign space_o    = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_data_o  = mem[rd_ptr_q];
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_comb begin
    count_d = count_q;
    unique case ({wr_valid_i, do_rd})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (wr_valid_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_rd) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_valid_i) begin
      mem[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule
